FILE: rtl/dstb_pkg.sv
// Shared types and constants for the delay and stopwatch timer bank.
`default_nettype none

package dstb_pkg;

    // Fixed field widths
    localparam int unsigned REQ_W   = 4;
    localparam int unsigned CH_W    = 4;
    localparam int unsigned COUNT_W = 16;

    // Command codes; 14 and 15 are no-ops
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK          = 4'd0,
        REQ_ALLOC_DELAY   = 4'd1,
        REQ_OPEN          = 4'd2,
        REQ_CHECK         = 4'd3,
        REQ_PAUSE         = 4'd4,
        REQ_RESUME        = 4'd5,
        REQ_RESUME_RELOAD = 4'd6,
        REQ_CLOSE         = 4'd7,
        REQ_SET_RELOAD    = 4'd8,
        REQ_ALLOC_WATCH   = 4'd9,
        REQ_OPEN_WATCH    = 4'd10,
        REQ_READ_WATCH    = 4'd11,
        REQ_PAUSE_WATCH   = 4'd12,
        REQ_RESUME_WATCH  = 4'd13
    } req_t;

    // Controller states: result register empty or holding a beat
    typedef enum logic {
        ST_EMPTY = 1'b0,
        ST_FULL  = 1'b1
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dstb_ctrl.sv
// Handshake controller: accepts command beats and tracks the result register.
`default_nettype none

module dstb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dstb_pkg::ctrl_cmd_t      cmd
);

    dstb_pkg::ctrl_state_t state_reg;
    dstb_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dstb_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs; a new beat may enter while the old one leaves
    always_comb
    begin
        in_stall   = (state_reg == dstb_pkg::ST_FULL) && out_stall;
        out_valid  = (state_reg == dstb_pkg::ST_FULL);
        cmd.exec   = in_valid && !in_stall;
        state_next = state_reg;
        case (state_reg)
            dstb_pkg::ST_EMPTY:
            begin
                if (cmd.exec)
                begin
                    state_next = dstb_pkg::ST_FULL;
                end
            end
            dstb_pkg::ST_FULL:
            begin
                if (!out_stall && !cmd.exec)
                begin
                    state_next = dstb_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                state_next = dstb_pkg::ST_EMPTY;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/dstb_datapath.sv
// Channel state lanes, allocation encoder and result register.
`default_nettype none

module dstb_datapath #(
    parameter int unsigned DELAY_CHANNELS = 16,
    parameter int unsigned WATCH_CHANNELS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dstb_pkg::ctrl_cmd_t               cmd,
    input  wire logic [dstb_pkg::REQ_W-1:0]        req_type,
    input  wire logic [dstb_pkg::CH_W-1:0]         channel,
    input  wire logic [dstb_pkg::COUNT_W-1:0]      value,
    output logic      [dstb_pkg::CH_W-1:0]         granted_channel,
    output logic                                   alloc_failed,
    output logic                                   delay_done,
    output logic      [dstb_pkg::COUNT_W-1:0]      elapsed
);

    localparam int unsigned CW = dstb_pkg::COUNT_W;

    dstb_pkg::req_t req;

    // Delay channel state
    logic [CW-1:0]             d_reload_reg [DELAY_CHANNELS];
    logic [CW-1:0]             d_reload_next [DELAY_CHANNELS];
    logic [CW-1:0]             d_rem_reg [DELAY_CHANNELS];
    logic [CW-1:0]             d_rem_next [DELAY_CHANNELS];
    logic [DELAY_CHANNELS-1:0] d_use_reg, d_use_next;
    logic [DELAY_CHANNELS-1:0] d_run_reg, d_run_next;
    logic [DELAY_CHANNELS-1:0] d_exp_reg, d_exp_next;
    logic [DELAY_CHANNELS-1:0] d_pause_reg, d_pause_next;

    // Stopwatch state
    logic [CW-1:0]             w_count_reg [WATCH_CHANNELS];
    logic [CW-1:0]             w_count_next [WATCH_CHANNELS];
    logic [WATCH_CHANNELS-1:0] w_use_reg, w_use_next;
    logic [WATCH_CHANNELS-1:0] w_run_reg, w_run_next;
    logic [WATCH_CHANNELS-1:0] w_saved_reg, w_saved_next;

    // Channel decode and allocation
    logic [DELAY_CHANNELS-1:0] d_sel;
    logic [WATCH_CHANNELS-1:0] w_sel;
    logic [DELAY_CHANNELS-1:0] d_free, d_grant;
    logic [WATCH_CHANNELS-1:0] w_free, w_grant;
    logic [dstb_pkg::CH_W-1:0] d_grant_idx, w_grant_idx;
    logic [CW-1:0]             d_dec [DELAY_CHANNELS];
    logic                      sel_expired;
    logic [CW-1:0]             sel_count;

    // Result register
    logic [dstb_pkg::CH_W-1:0] granted_reg, granted_next;
    logic                      failed_reg, failed_next;
    logic                      done_reg, done_next;
    logic [CW-1:0]             elapsed_reg, elapsed_next;

    assign req = dstb_pkg::req_t'(req_type);

    // Lowest free channel: isolate the lowest set bit of the free mask
    assign d_free  = ~d_use_reg;
    assign w_free  = ~w_use_reg;
    assign d_grant = d_free & (~d_free + {{(DELAY_CHANNELS-1){1'b0}}, 1'b1});
    assign w_grant = w_free & (~w_free + {{(WATCH_CHANNELS-1){1'b0}}, 1'b1});

    // Lane select, grant index encode and read-back of the addressed lane
    always_comb
    begin
        d_grant_idx = '0;
        w_grant_idx = '0;
        sel_expired = 1'b0;
        sel_count   = '0;
        for (int i = 0; i < DELAY_CHANNELS; i++)
        begin
            d_sel[i] = (channel == dstb_pkg::CH_W'(i));
            d_dec[i] = d_rem_reg[i] - CW'(1);
            if (d_grant[i])
            begin
                d_grant_idx = d_grant_idx | dstb_pkg::CH_W'(i);
            end
            sel_expired = sel_expired | (d_sel[i] & d_exp_reg[i]);
        end
        for (int i = 0; i < WATCH_CHANNELS; i++)
        begin
            w_sel[i] = (channel == dstb_pkg::CH_W'(i));
            if (w_grant[i])
            begin
                w_grant_idx = w_grant_idx | dstb_pkg::CH_W'(i);
            end
            sel_count = sel_count | ({CW{w_sel[i]}} & w_count_reg[i]);
        end
    end

    // Delay lanes next state
    always_comb
    begin
        for (int i = 0; i < DELAY_CHANNELS; i++)
        begin
            d_reload_next[i] = d_reload_reg[i];
            d_rem_next[i]    = d_rem_reg[i];
            d_use_next[i]    = d_use_reg[i];
            d_run_next[i]    = d_run_reg[i];
            d_exp_next[i]    = d_exp_reg[i];
            d_pause_next[i]  = d_pause_reg[i];
            case (req)
                dstb_pkg::REQ_TICK:
                begin
                    if (d_run_reg[i] && !d_exp_reg[i])
                    begin
                        d_rem_next[i] = d_dec[i];
                        if (d_dec[i] == '0)
                        begin
                            d_exp_next[i] = 1'b1;
                        end
                    end
                end
                dstb_pkg::REQ_ALLOC_DELAY:
                begin
                    if (d_grant[i])
                    begin
                        d_reload_next[i] = value;
                        d_use_next[i]    = 1'b1;
                    end
                end
                dstb_pkg::REQ_OPEN:
                begin
                    if (d_sel[i])
                    begin
                        d_rem_next[i]   = d_reload_reg[i];
                        d_run_next[i]   = 1'b1;
                        d_exp_next[i]   = 1'b0;
                        d_pause_next[i] = 1'b0;
                    end
                end
                dstb_pkg::REQ_CHECK:
                begin
                    if (d_sel[i] && d_exp_reg[i])
                    begin
                        d_exp_next[i] = 1'b0;
                        d_run_next[i] = 1'b0;
                    end
                end
                dstb_pkg::REQ_PAUSE:
                begin
                    if (d_sel[i])
                    begin
                        d_pause_next[i] = d_run_reg[i];
                        d_run_next[i]   = 1'b0;
                    end
                end
                dstb_pkg::REQ_RESUME, dstb_pkg::REQ_RESUME_RELOAD:
                begin
                    if (d_sel[i])
                    begin
                        d_run_next[i]   = d_pause_reg[i];
                        d_pause_next[i] = 1'b0;
                        if (req == dstb_pkg::REQ_RESUME_RELOAD)
                        begin
                            d_rem_next[i] = d_reload_reg[i];
                        end
                    end
                end
                dstb_pkg::REQ_CLOSE:
                begin
                    if (d_sel[i])
                    begin
                        d_run_next[i]   = 1'b0;
                        d_exp_next[i]   = 1'b0;
                        d_pause_next[i] = 1'b0;
                        d_rem_next[i]   = '0;
                    end
                end
                dstb_pkg::REQ_SET_RELOAD:
                begin
                    if (d_sel[i])
                    begin
                        d_reload_next[i] = value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stopwatch lanes next state
    always_comb
    begin
        for (int i = 0; i < WATCH_CHANNELS; i++)
        begin
            w_count_next[i] = w_count_reg[i];
            w_use_next[i]   = w_use_reg[i];
            w_run_next[i]   = w_run_reg[i];
            w_saved_next[i] = w_saved_reg[i];
            case (req)
                dstb_pkg::REQ_TICK:
                begin
                    if (w_run_reg[i])
                    begin
                        w_count_next[i] = w_count_reg[i] + CW'(1);
                    end
                end
                dstb_pkg::REQ_ALLOC_WATCH:
                begin
                    if (w_grant[i])
                    begin
                        w_use_next[i] = 1'b1;
                    end
                end
                dstb_pkg::REQ_OPEN_WATCH:
                begin
                    if (w_sel[i] && !w_run_reg[i])
                    begin
                        w_count_next[i] = '0;
                        w_run_next[i]   = 1'b1;
                    end
                end
                dstb_pkg::REQ_READ_WATCH:
                begin
                    if (w_sel[i] && w_run_reg[i])
                    begin
                        w_count_next[i] = '0;
                        w_run_next[i]   = 1'b0;
                    end
                end
                dstb_pkg::REQ_PAUSE_WATCH:
                begin
                    if (w_sel[i])
                    begin
                        w_saved_next[i] = w_run_reg[i];
                        w_run_next[i]   = 1'b0;
                    end
                end
                dstb_pkg::REQ_RESUME_WATCH:
                begin
                    if (w_sel[i])
                    begin
                        w_run_next[i] = w_saved_reg[i];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result beat
    always_comb
    begin
        granted_next = '0;
        failed_next  = 1'b0;
        done_next    = 1'b0;
        elapsed_next = '0;
        case (req)
            dstb_pkg::REQ_ALLOC_DELAY:
            begin
                failed_next  = ~|d_free;
                granted_next = d_grant_idx;
            end
            dstb_pkg::REQ_ALLOC_WATCH:
            begin
                failed_next  = ~|w_free;
                granted_next = w_grant_idx;
            end
            dstb_pkg::REQ_CHECK:
            begin
                done_next = sel_expired;
            end
            dstb_pkg::REQ_READ_WATCH:
            begin
                elapsed_next = sel_count;
            end
            default:
            begin
            end
        endcase
    end

    // Channel state registers, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DELAY_CHANNELS; i++)
            begin
                d_reload_reg[i] <= '0;
                d_rem_reg[i]    <= '0;
            end
            d_use_reg   <= '0;
            d_run_reg   <= '0;
            d_exp_reg   <= '0;
            d_pause_reg <= '0;
            for (int i = 0; i < WATCH_CHANNELS; i++)
            begin
                w_count_reg[i] <= '0;
            end
            w_use_reg   <= '0;
            w_run_reg   <= '0;
            w_saved_reg <= '0;
        end
        else if (cmd.exec)
        begin
            d_reload_reg <= d_reload_next;
            d_rem_reg    <= d_rem_next;
            d_use_reg    <= d_use_next;
            d_run_reg    <= d_run_next;
            d_exp_reg    <= d_exp_next;
            d_pause_reg  <= d_pause_next;
            w_count_reg  <= w_count_next;
            w_use_reg    <= w_use_next;
            w_run_reg    <= w_run_next;
            w_saved_reg  <= w_saved_next;
        end
    end

    // Result register: payload only, loaded when a beat is accepted
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            granted_reg <= granted_next;
            failed_reg  <= failed_next;
            done_reg    <= done_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign granted_channel = granted_reg;
    assign alloc_failed    = failed_reg;
    assign delay_done      = done_reg;
    assign elapsed         = elapsed_reg;

endmodule

`default_nettype wire

FILE: rtl/delay_and_stopwatch_timer_bank_top.sv
// A result beat is valid in the cycle after its command beat is accepted.
// Throughput: one command per cycle if not stalled; all channels tick in parallel
// and the result register lets a new command enter while the old result leaves.
// A command is stalled only while the result register is full and stalled.
// Reset (async, active low) clears all delay and stopwatch channels at once.
`default_nettype none

module delay_and_stopwatch_timer_bank_top #(
    parameter int unsigned DELAY_CHANNELS = 16,
    parameter int unsigned WATCH_CHANNELS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [dstb_pkg::REQ_W-1:0]    req_type,
    input  wire logic [dstb_pkg::CH_W-1:0]     channel,
    input  wire logic [dstb_pkg::COUNT_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [dstb_pkg::CH_W-1:0]     granted_channel,
    output logic                               alloc_failed,
    output logic                               delay_done,
    output logic      [dstb_pkg::COUNT_W-1:0]  elapsed
);

    dstb_pkg::ctrl_cmd_t cmd;

    // Handshake controller
    dstb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Channel datapath
    dstb_datapath #(
        .DELAY_CHANNELS (DELAY_CHANNELS),
        .WATCH_CHANNELS (WATCH_CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .req_type        (req_type),
        .channel         (channel),
        .value           (value),
        .granted_channel (granted_channel),
        .alloc_failed    (alloc_failed),
        .delay_done      (delay_done),
        .elapsed         (elapsed)
    );

endmodule

`default_nettype wire
